@@ hw/rtl/spi_pkg.sv @@
// ----------------------------------------------------------------------------
// spi_pkg
// Types, widths and constants shared by the segment/plane intersection block.
// ----------------------------------------------------------------------------
package spi_pkg;

    localparam int FRAC_BITS_DEF = 16;   // valid range 8 to 24
    localparam int WORD_W        = 32;
    localparam int QUO_W         = 32;   // quotient bits produced by the divider
    localparam int WIDE_W        = 66;   // n.p1 + d and n.(p2 - p1), signed
    localparam int MAG_W         = 65;   // magnitude of a WIDE_W value
    localparam int PROD_W        = 65;   // (p2 - p1) * s, signed

    typedef logic signed [WORD_W-1:0] t_s32;
    typedef logic signed [WORD_W:0]   t_s33;
    typedef logic signed [63:0]       t_s64;
    typedef logic signed [PROD_W-1:0] t_s65;
    typedef logic signed [WIDE_W-1:0] t_wide;

    localparam t_s32 S32_MAX = 32'sh7FFF_FFFF;
    localparam t_s32 S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        t_s32 normal_x;
        t_s32 normal_y;
        t_s32 normal_z;
        t_s32 plane_offset;
        t_s32 start_x;
        t_s32 start_y;
        t_s32 start_z;
        t_s32 end_x;
        t_s32 end_y;
        t_s32 end_z;
    } t_query;

    typedef struct packed {
        t_s32 p1_x;
        t_s32 p1_y;
        t_s32 p1_z;
        t_s33 dv_x;
        t_s33 dv_y;
        t_s33 dv_z;
    } t_geom;

    typedef struct packed {
        t_geom             geom;
        logic              neg;
        logic              par;
        logic              ovf;
        logic [MAG_W-1:0]  rem;
        logic [MAG_W-1:0]  dvs;
        logic [QUO_W-1:0]  lo;
        logic [QUO_W-1:0]  quo;
    } t_div;

    typedef struct packed {
        t_s32 hit_x;
        t_s32 hit_y;
        t_s32 hit_z;
        logic parallel;
        logic within_segment;
        logic saturated;
    } t_result;

endpackage

@@ hw/rtl/spi_in_if.sv @@
// ----------------------------------------------------------------------------
// spi_in_if
// Query channel: plane and line end points, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spi_in_if;
    import spi_pkg::*;

    logic valid;
    logic ready;
    t_s32 normal_x;
    t_s32 normal_y;
    t_s32 normal_z;
    t_s32 plane_offset;
    t_s32 start_x;
    t_s32 start_y;
    t_s32 start_z;
    t_s32 end_x;
    t_s32 end_y;
    t_s32 end_z;

    modport source (
        output valid, normal_x, normal_y, normal_z, plane_offset,
               start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );

    modport sink (
        input  valid, normal_x, normal_y, normal_z, plane_offset,
               start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

@@ hw/rtl/spi_out_if.sv @@
// ----------------------------------------------------------------------------
// spi_out_if
// Result channel: intersection point and flags, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spi_out_if;
    import spi_pkg::*;

    logic valid;
    logic ready;
    t_s32 hit_x;
    t_s32 hit_y;
    t_s32 hit_z;
    logic parallel;
    logic within_segment;
    logic saturated;

    modport source (
        output valid, hit_x, hit_y, hit_z, parallel, within_segment, saturated,
        input  ready
    );

    modport sink (
        input  valid, hit_x, hit_y, hit_z, parallel, within_segment, saturated,
        output ready
    );
endinterface

@@ hw/rtl/spi_front.sv @@
// ----------------------------------------------------------------------------
// spi_front
// Five stages: direction vector, products, dot product sums, magnitudes and
// signs, then divider setup with quotient overflow detection.
// ----------------------------------------------------------------------------
module spi_front
    import spi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_en,
    input  logic   i_vld,
    input  t_query i_query,
    output logic   o_vld,
    output t_div   o_div
);

    localparam int SHIFT_HI = QUO_W - FRAC_BITS;

    logic   r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;

    t_query r_s1_q;
    t_s33   r_s1_dv_x, r_s1_dv_y, r_s1_dv_z;
    t_s33   n_s1_dv_x, n_s1_dv_y, n_s1_dv_z;

    t_s64   r_s2_pn_x, r_s2_pn_y, r_s2_pn_z;
    t_s65   r_s2_pd_x, r_s2_pd_y, r_s2_pd_z;
    t_wide  r_s2_off;
    t_geom  r_s2_geom;
    t_geom  n_s2_geom;

    t_wide  r_s3_num, r_s3_den;
    t_geom  r_s3_geom;
    t_wide  n_s3_num, n_s3_den;

    logic [MAG_W-1:0] r_s4_mnum, r_s4_mden;
    logic             r_s4_neg, r_s4_par;
    t_geom            r_s4_geom;

    logic [MAG_W-1:0] n_s5_hi;
    t_div             r_s5_div;

    always_comb begin
        n_s1_dv_x = t_s33'(i_query.end_x) - t_s33'(i_query.start_x);
        n_s1_dv_y = t_s33'(i_query.end_y) - t_s33'(i_query.start_y);
        n_s1_dv_z = t_s33'(i_query.end_z) - t_s33'(i_query.start_z);

        n_s2_geom.p1_x = r_s1_q.start_x;
        n_s2_geom.p1_y = r_s1_q.start_y;
        n_s2_geom.p1_z = r_s1_q.start_z;
        n_s2_geom.dv_x = r_s1_dv_x;
        n_s2_geom.dv_y = r_s1_dv_y;
        n_s2_geom.dv_z = r_s1_dv_z;

        n_s3_num = -(t_wide'(r_s2_pn_x) + t_wide'(r_s2_pn_y) + t_wide'(r_s2_pn_z)
                     + r_s2_off);
        n_s3_den = t_wide'(r_s2_pd_x) + t_wide'(r_s2_pd_y) + t_wide'(r_s2_pd_z);

        n_s5_hi = MAG_W'(r_s4_mnum >> SHIFT_HI);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_vld;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_q    <= i_query;
            r_s1_dv_x <= n_s1_dv_x;
            r_s1_dv_y <= n_s1_dv_y;
            r_s1_dv_z <= n_s1_dv_z;

            r_s2_pn_x <= r_s1_q.normal_x * r_s1_q.start_x;
            r_s2_pn_y <= r_s1_q.normal_y * r_s1_q.start_y;
            r_s2_pn_z <= r_s1_q.normal_z * r_s1_q.start_z;
            r_s2_pd_x <= r_s1_q.normal_x * r_s1_dv_x;
            r_s2_pd_y <= r_s1_q.normal_y * r_s1_dv_y;
            r_s2_pd_z <= r_s1_q.normal_z * r_s1_dv_z;
            r_s2_off  <= t_wide'(r_s1_q.plane_offset) <<< FRAC_BITS;
            r_s2_geom <= n_s2_geom;

            r_s3_num  <= n_s3_num;
            r_s3_den  <= n_s3_den;
            r_s3_geom <= r_s2_geom;

            r_s4_mnum <= r_s3_num[WIDE_W-1] ? MAG_W'(-r_s3_num) : MAG_W'(r_s3_num);
            r_s4_mden <= r_s3_den[WIDE_W-1] ? MAG_W'(-r_s3_den) : MAG_W'(r_s3_den);
            r_s4_neg  <= r_s3_num[WIDE_W-1] ^ r_s3_den[WIDE_W-1];
            r_s4_par  <= (r_s3_den == '0);
            r_s4_geom <= r_s3_geom;

            r_s5_div.geom <= r_s4_geom;
            r_s5_div.neg  <= r_s4_neg;
            r_s5_div.par  <= r_s4_par;
            r_s5_div.ovf  <= (n_s5_hi >= r_s4_mden);
            r_s5_div.rem  <= n_s5_hi;
            r_s5_div.dvs  <= r_s4_mden;
            r_s5_div.lo   <= QUO_W'({r_s4_mnum, {FRAC_BITS{1'b0}}});
            r_s5_div.quo  <= '0;
        end
    end

    assign o_vld = r_s5_vld;
    assign o_div = r_s5_div;

endmodule

@@ hw/rtl/spi_div_step.sv @@
// ----------------------------------------------------------------------------
// spi_div_step
// One registered step of the restoring divider: bring down a dividend bit,
// compare against the divisor, subtract and shift in one quotient bit.
// ----------------------------------------------------------------------------
module spi_div_step
    import spi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_vld,
    input  t_div i_div,
    output logic o_vld,
    output t_div o_div
);

    logic             r_vld;
    t_div             r_div;
    t_div             n_div;
    logic [MAG_W:0]   n_part;
    logic [MAG_W:0]   n_dvs;
    logic             n_ge;

    always_comb begin
        n_part = {i_div.rem, i_div.lo[QUO_W-1]};
        n_dvs  = {1'b0, i_div.dvs};
        n_ge   = (n_part >= n_dvs);

        n_div     = i_div;
        n_div.rem = n_ge ? MAG_W'(n_part - n_dvs) : MAG_W'(n_part);
        n_div.lo  = {i_div.lo[QUO_W-2:0], 1'b0};
        n_div.quo = {i_div.quo[QUO_W-2:0], n_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_vld = r_vld;
    assign o_div = r_div;

endmodule

@@ hw/rtl/spi_back.sv @@
// ----------------------------------------------------------------------------
// spi_back
// Three stages: signed, saturated line parameter; direction times parameter;
// floor shift, add to the start point and clip each coordinate, or flag parallel.
// ----------------------------------------------------------------------------
module spi_back
    import spi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_div    i_div,
    output logic    o_vld,
    output t_result o_res
);

    localparam t_s32 ONE_Q = t_s32'(64'd1 << FRAC_BITS);

    typedef struct packed {
        t_s32 val;
        logic sat;
    } t_clip;

    function automatic t_clip clip_add(t_s32 p, t_s65 sh);
        t_wide sum;
        t_clip res;
        sum = t_wide'(p) + t_wide'(sh);
        if (sum > t_wide'(S32_MAX)) begin
            res.val = S32_MAX;
            res.sat = 1'b1;
        end else if (sum < t_wide'(S32_MIN)) begin
            res.val = S32_MIN;
            res.sat = 1'b1;
        end else begin
            res.val = t_s32'(sum);
            res.sat = 1'b0;
        end
        return res;
    endfunction

    logic    r_a_vld, r_b_vld, r_c_vld;

    t_s32    n_a_s;
    logic    n_a_sat;
    t_s32    r_a_s;
    logic    r_a_sat, r_a_within, r_a_par;
    t_geom   r_a_geom;

    t_s65    r_b_prod_x, r_b_prod_y, r_b_prod_z;
    logic    r_b_sat, r_b_within, r_b_par;
    t_geom   r_b_geom;

    t_clip   n_c_x, n_c_y, n_c_z;
    t_result n_c_res;
    t_result r_c_res;

    always_comb begin
        if (i_div.neg) begin
            n_a_sat = i_div.ovf || (i_div.quo > 32'h8000_0000);
            n_a_s   = n_a_sat ? S32_MIN : t_s32'(-{1'b0, i_div.quo});
        end else begin
            n_a_sat = i_div.ovf || i_div.quo[QUO_W-1];
            n_a_s   = n_a_sat ? S32_MAX : t_s32'(i_div.quo);
        end

        n_c_x = clip_add(r_b_geom.p1_x, r_b_prod_x >>> FRAC_BITS);
        n_c_y = clip_add(r_b_geom.p1_y, r_b_prod_y >>> FRAC_BITS);
        n_c_z = clip_add(r_b_geom.p1_z, r_b_prod_z >>> FRAC_BITS);

        if (r_b_par) begin
            n_c_res = '0;
            n_c_res.parallel = 1'b1;
        end else begin
            n_c_res.hit_x          = n_c_x.val;
            n_c_res.hit_y          = n_c_y.val;
            n_c_res.hit_z          = n_c_z.val;
            n_c_res.parallel       = 1'b0;
            n_c_res.within_segment = r_b_within;
            n_c_res.saturated      = r_b_sat | n_c_x.sat | n_c_y.sat | n_c_z.sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_s      <= n_a_s;
            r_a_sat    <= n_a_sat;
            r_a_within <= (n_a_s > 32'sd0) && (n_a_s < ONE_Q);
            r_a_par    <= i_div.par;
            r_a_geom   <= i_div.geom;

            r_b_prod_x <= r_a_geom.dv_x * r_a_s;
            r_b_prod_y <= r_a_geom.dv_y * r_a_s;
            r_b_prod_z <= r_a_geom.dv_z * r_a_s;
            r_b_sat    <= r_a_sat;
            r_b_within <= r_a_within;
            r_b_par    <= r_a_par;
            r_b_geom   <= r_a_geom;

            r_c_res    <= n_c_res;
        end
    end

    assign o_vld = r_c_vld;
    assign o_res = r_c_res;

endmodule

@@ hw/rtl/segment_plane_intersection.sv @@
// ----------------------------------------------------------------------------
// segment_plane_intersection
// Intersects a line, given by two points, with a plane n.x + d = 0, all in
// signed Q(32-FRAC_BITS).FRAC_BITS fixed point.
//
// Usage:
//   i_in carries one query item (normal, offset, start and end point) under a
//   valid/ready handshake; o_out returns one result item per query, in order:
//   the hit point, a parallel flag, a within-segment flag and a clip flag.
//   Throughput is one item per cycle while i_in.ready is high. A result
//   reaches o_out through 5 front stages (products, dot sums, setup),
//   32 divider stages (one quotient bit each), 3 back stages (parameter,
//   multiply, clip), then the output register.
//   When the receiver stalls, the pipeline keeps moving until one more item
//   has landed in a skid register behind the output register; then i_in.ready
//   drops and every stage holds. Bubbles are not squeezed out.
//   Synchronous reset clears all valid bits; no result is pending after it.
// ----------------------------------------------------------------------------
module segment_plane_intersection
    import spi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spi_in_if.sink    i_in,
    spi_out_if.source o_out
);

    logic    w_en;
    t_query  w_query;
    logic    w_dvld [QUO_W+1];
    t_div    w_div  [QUO_W+1];
    logic    w_last_vld;
    t_result w_last_res;
    logic    w_take;

    logic    r_out_vld, r_skid_vld;
    t_result r_out, r_skid;

    assign w_en       = !r_skid_vld;
    assign i_in.ready = w_en;
    assign w_take     = r_out_vld && o_out.ready;

    always_comb begin
        w_query.normal_x     = i_in.normal_x;
        w_query.normal_y     = i_in.normal_y;
        w_query.normal_z     = i_in.normal_z;
        w_query.plane_offset = i_in.plane_offset;
        w_query.start_x      = i_in.start_x;
        w_query.start_y      = i_in.start_y;
        w_query.start_z      = i_in.start_z;
        w_query.end_x        = i_in.end_x;
        w_query.end_y        = i_in.end_y;
        w_query.end_z        = i_in.end_z;
    end

    spi_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_in.valid),
        .i_query (w_query),
        .o_vld   (w_dvld[0]),
        .o_div   (w_div[0])
    );

    for (genvar k = 0; k < QUO_W; k++) begin : g_div
        spi_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_dvld[k]),
            .i_div   (w_div[k]),
            .o_vld   (w_dvld[k+1]),
            .o_div   (w_div[k+1])
        );
    end

    spi_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_dvld[QUO_W]),
        .i_div   (w_div[QUO_W]),
        .o_vld   (w_last_vld),
        .o_res   (w_last_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_take || !r_out_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (w_last_vld) begin
            if (!r_out_vld || w_take) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_take) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_take || !r_out_vld) begin
                r_out <= r_skid;
            end
        end else if (w_last_vld) begin
            if (!r_out_vld || w_take) begin
                r_out <= w_last_res;
            end else begin
                r_skid <= w_last_res;
            end
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.hit_x          = r_out.hit_x;
    assign o_out.hit_y          = r_out.hit_y;
    assign o_out.hit_z          = r_out.hit_z;
    assign o_out.parallel       = r_out.parallel;
    assign o_out.within_segment = r_out.within_segment;
    assign o_out.saturated      = r_out.saturated;

endmodule
